@@ hdl/crsh_pkg.sv @@
// Shared types, constants and the multiply-accumulate schedule of the ray-sphere hit search.
package crsh_pkg;

   localparam int OPND_W     = 68;   // signed operand width of the shared multiplier
   localparam int DIG_W      = 17;   // multiplier digit width
   localparam int DIGITS     = 4;    // digits per operand
   localparam int ACC_W      = 136;  // accumulator width
   localparam int MAC_OPS    = 12;   // products per sphere
   localparam int SQRT_STEPS = 67;   // root bits
   localparam int Q_BITS     = 31;   // quotient bits
   localparam int ENTRY_W    = 127;  // center x/y/z and radius

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_GEOM,
      ST_MAC,
      ST_CHECK,
      ST_SQRT,
      ST_NUM,
      ST_DIV,
      ST_PICK,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      SRC_DX, SRC_DY, SRC_DZ, SRC_OCX, SRC_OCY, SRC_OCZ, SRC_RAD, SRC_A, SRC_HB, SRC_C
   } src_type;

   typedef enum logic [1:0] {
      DST_NONE, DST_A, DST_HB, DST_C
   } dst_type;

   typedef enum logic [1:0] {
      REG_COUNT = 2'd0,
      REG_TMIN  = 2'd1,
      REG_TMAX  = 2'd2,
      REG_SPARE = 2'd3
   } reg_type;

   localparam logic MODE_LOAD = 1'b0;

   typedef struct packed {
      src_type x;
      src_type y;
      logic    neg;
      logic    clr;
      dst_type dst;
   } mac_op_type;

   // a = d.d, half_b = oc.d, c = oc.oc - r*r, disc = half_b^2 - a*c
   function automatic mac_op_type mac_op(input logic [3:0] k);
      mac_op_type op;
      unique case (k)
         4'd0:    op = '{SRC_DX,  SRC_DX,  1'b0, 1'b1, DST_NONE};
         4'd1:    op = '{SRC_DY,  SRC_DY,  1'b0, 1'b0, DST_NONE};
         4'd2:    op = '{SRC_DZ,  SRC_DZ,  1'b0, 1'b0, DST_A};
         4'd3:    op = '{SRC_OCX, SRC_DX,  1'b0, 1'b1, DST_NONE};
         4'd4:    op = '{SRC_OCY, SRC_DY,  1'b0, 1'b0, DST_NONE};
         4'd5:    op = '{SRC_OCZ, SRC_DZ,  1'b0, 1'b0, DST_HB};
         4'd6:    op = '{SRC_OCX, SRC_OCX, 1'b0, 1'b1, DST_NONE};
         4'd7:    op = '{SRC_OCY, SRC_OCY, 1'b0, 1'b0, DST_NONE};
         4'd8:    op = '{SRC_OCZ, SRC_OCZ, 1'b0, 1'b0, DST_NONE};
         4'd9:    op = '{SRC_RAD, SRC_RAD, 1'b1, 1'b0, DST_C};
         4'd10:   op = '{SRC_HB,  SRC_HB,  1'b0, 1'b1, DST_NONE};
         default: op = '{SRC_A,   SRC_C,   1'b1, 1'b0, DST_NONE};
      endcase
      return op;
   endfunction

endpackage

@@ hdl/crsh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module crsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ hdl/closest_ray_sphere_hit.sv @@
// Closest ray-sphere hit search over a sphere table with one shared multiply-accumulate unit.
//
// Usage:
//  - req channel: one transaction per item. tuser = mode (0 load, 1 trace). A load writes
//    the sphere in tdata into table slot 'slot' and returns nothing.
//  - A trace transaction searches slots 0 .. min(sphere_count, SPHERES)-1 and returns one
//    rsp transaction: tuser = hit, tdata = hit_slot and distance (Q15.16).
//  - Per searched slot the sequencer fetches the entry and forms origin - center, runs
//    the shared 68x17 multiplier (12 exact wide products in 4 digits each), then a check,
//    the bit-by-bit square root, the restoring divider and the pick. A slot that misses
//    early (negative discriminant, zero-length direction, non-positive or out-of-range
//    numerator) ends sooner.
//  - req_tready is high only while idle; one item is worked on at a time.
//  - The result sits in an output register; the next item is accepted while it waits.
//    A trace that finishes while the previous result is still stalled holds until it goes.
//  - Reset: sphere_count = 0, t_min = 66, t_max = 2^31-1, no pending result. Table
//    contents are undefined until loaded; there is no clearing pass.
//  - Write csr registers only while the block is idle.
module closest_ray_sphere_hit
   import crsh_pkg::*;
#(
   parameter int SPHERES = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [231:0] req_tdata,   // slot[3:0], pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                                     // radius[226:196], zero pad
   input  logic [0:0]   req_tuser,   // mode
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // hit_slot[3:0], distance[34:4], zero pad
   output logic [0:0]   rsp_tuser,   // hit
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int AW = (SPHERES > 1) ? $clog2(SPHERES) : 1;
   localparam int CW = $clog2(SPHERES + 1);

   // ---------------------------------------------------------------- registers
   logic [4:0]  cnt_ff;
   logic [30:0] tmin_ff, tmax_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 5'd0;
         tmin_ff <= 31'd66;
         tmax_ff <= 31'h7FFF_FFFF;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_type'(csr_paddr[3:2]))
            REG_COUNT: cnt_ff  <= csr_pwdata[4:0];
            REG_TMIN:  tmin_ff <= csr_pwdata[30:0];
            REG_TMAX:  tmax_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_type'(csr_paddr[3:2]))
         REG_COUNT: csr_prdata = {27'd0, cnt_ff};
         REG_TMIN:  csr_prdata = {1'b0, tmin_ff};
         REG_TMAX:  csr_prdata = {1'b0, tmax_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- sequencer state
   state_type state_ff, state_in;
   logic      req_take, ram_we, rsp_load;
   logic      mac_last, sqrt_last, div_last, num_ok, geo_miss, scan_end;

   logic [CW-1:0]  idx_ff;
   logic [3:0]     op_ff;
   logic [1:0]     dig_ff;
   logic [6:0]     iter_ff;

   // table read/write
   logic [AW-1:0]        wr_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [8:0]           lim9;

   assign wr_addr = AW'(req_tdata[3:0]);
   assign lim9 = ({4'd0, cnt_ff} > 9'(SPHERES)) ? 9'(SPHERES) : {4'd0, cnt_ff};
   assign scan_end = 9'(idx_ff) >= lim9;

   crsh_ram #(.WIDTH(ENTRY_W), .DEPTH(SPHERES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data ({req_tdata[226:196], req_tdata[99:4]}),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- datapath registers
   logic signed [31:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [32:0] ocx_ff, ocy_ff, ocz_ff;
   logic [30:0]        rad_ff;
   logic signed [OPND_W-1:0] a_ff, hb_ff, c_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [133:0]       sv_ff;
   logic [70:0]        rem_ff;
   logic [66:0]        root_ff;
   logic [84:0]        drem_ff;
   logic [97:0]        dsor_ff;
   logic [30:0]        q_ff;
   logic [30:0]        best_ff;
   logic [3:0]         bslot_ff;
   logic               hit_ff;
   logic               rsp_valid_ff;
   logic [3:0]         rsp_slot_ff;
   logic [30:0]        rsp_dist_ff;
   logic               rsp_hit_ff;

   // ---------------------------------------------------------------- shared multiplier
   mac_op_type               op;
   logic signed [OPND_W-1:0] opx, opy;
   logic [OPND_W-1:0]        magx, magy;
   logic [DIG_W-1:0]         digit;
   logic [OPND_W+DIG_W-1:0]  pp;
   logic [ACC_W-1:0]         pp_sh, acc_base, acc_in;
   logic                     negp;

   function automatic logic signed [OPND_W-1:0] sel_opnd(input src_type s);
      logic signed [OPND_W-1:0] v;
      case (s)
         SRC_DX:  v = OPND_W'(dx_ff);
         SRC_DY:  v = OPND_W'(dy_ff);
         SRC_DZ:  v = OPND_W'(dz_ff);
         SRC_OCX: v = OPND_W'(ocx_ff);
         SRC_OCY: v = OPND_W'(ocy_ff);
         SRC_OCZ: v = OPND_W'(ocz_ff);
         SRC_RAD: v = OPND_W'(rad_ff);
         SRC_A:   v = a_ff;
         SRC_HB:  v = hb_ff;
         default: v = c_ff;
      endcase
      return v;
   endfunction

   always_comb begin
      op       = mac_op(op_ff);
      opx      = sel_opnd(op.x);
      opy      = sel_opnd(op.y);
      magx     = opx[OPND_W-1] ? OPND_W'(-opx) : OPND_W'(opx);
      magy     = opy[OPND_W-1] ? OPND_W'(-opy) : OPND_W'(opy);
      digit    = magy[dig_ff*DIG_W +: DIG_W];
      pp       = (OPND_W+DIG_W)'(magx) * (OPND_W+DIG_W)'(digit);
      pp_sh    = ACC_W'(pp) << (DIG_W * dig_ff);
      negp     = opx[OPND_W-1] ^ opy[OPND_W-1] ^ op.neg;
      acc_base = (op.clr && dig_ff == 2'd0) ? '0 : acc_ff;
      acc_in   = negp ? acc_base - pp_sh : acc_base + pp_sh;
   end

   // ---------------------------------------------------------------- root, numerator, divider
   logic [70:0]        rem_t, trial;
   logic               sq_ge;
   logic signed [69:0] num_w;
   logic               dge;

   assign rem_t = {rem_ff[68:0], sv_ff[133:132]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign sq_ge = rem_t >= trial;

   assign num_w  = -70'(hb_ff) - 70'(root_ff);
   assign num_ok = !num_w[69] && (num_w != 70'd0) &&
                   (83'(num_w[68:0]) < {a_ff[67:0], 15'd0});

   assign dge = {13'd0, drem_ff} >= dsor_ff;

   assign mac_last  = (op_ff == 4'(MAC_OPS - 1)) && (dig_ff == 2'(DIGITS - 1));
   assign sqrt_last = iter_ff == 7'(SQRT_STEPS - 1);
   assign div_last  = iter_ff == 7'(Q_BITS - 1);
   assign geo_miss  = (a_ff == '0) || acc_ff[ACC_W-1];

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take && req_tuser[0] != MODE_LOAD) state_in = ST_FETCH;
         ST_FETCH: state_in = scan_end ? ST_DONE : ST_GEOM;
         ST_GEOM:  state_in = ST_MAC;
         ST_MAC:   if (mac_last) state_in = ST_CHECK;
         ST_CHECK: state_in = geo_miss ? ST_NEXT : ST_SQRT;
         ST_SQRT:  if (sqrt_last) state_in = ST_NUM;
         ST_NUM:   state_in = num_ok ? ST_DIV : ST_NEXT;
         ST_DIV:   if (div_last) state_in = ST_PICK;
         ST_PICK:  state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_FETCH;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control outputs
   always_comb begin
      req_tready = state_ff == ST_IDLE;
      req_take   = req_tvalid && req_tready;
      ram_we     = req_take && (req_tuser[0] == MODE_LOAD) &&
                   (9'(req_tdata[3:0]) < 9'(SPHERES));
      rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            // latch the ray and open the search window
            if (req_take) begin
               ox_ff    <= req_tdata[35:4];
               oy_ff    <= req_tdata[67:36];
               oz_ff    <= req_tdata[99:68];
               dx_ff    <= req_tdata[131:100];
               dy_ff    <= req_tdata[163:132];
               dz_ff    <= req_tdata[195:164];
               best_ff  <= tmax_ff;
               bslot_ff <= 4'd0;
               hit_ff   <= 1'b0;
               idx_ff   <= '0;
            end
         end
         ST_GEOM: begin
            ocx_ff <= 33'(ox_ff) - 33'($signed(rd_data[31:0]));
            ocy_ff <= 33'(oy_ff) - 33'($signed(rd_data[63:32]));
            ocz_ff <= 33'(oz_ff) - 33'($signed(rd_data[95:64]));
            rad_ff <= rd_data[126:96];
            op_ff  <= 4'd0;
            dig_ff <= 2'd0;
         end
         ST_MAC: begin
            acc_ff <= acc_in;
            dig_ff <= dig_ff + 2'd1;
            if (dig_ff == 2'(DIGITS - 1)) begin
               op_ff <= op_ff + 4'd1;
               case (op.dst)
                  DST_A:   a_ff  <= acc_in[OPND_W-1:0];
                  DST_HB:  hb_ff <= acc_in[OPND_W-1:0];
                  DST_C:   c_ff  <= acc_in[OPND_W-1:0];
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            sv_ff   <= acc_ff[133:0];
            rem_ff  <= '0;
            root_ff <= '0;
            iter_ff <= 7'd0;
         end
         ST_SQRT: begin
            // take two radicand bits, try the next root bit
            rem_ff  <= sq_ge ? rem_t - trial : rem_t;
            root_ff <= {root_ff[65:0], sq_ge};
            sv_ff   <= {sv_ff[131:0], 2'b00};
            iter_ff <= iter_ff + 7'd1;
         end
         ST_NUM: begin
            drem_ff <= {num_w[68:0], 16'd0};
            dsor_ff <= {a_ff[67:0], 30'd0};
            q_ff    <= '0;
            iter_ff <= 7'd0;
         end
         ST_DIV: begin
            if (dge) begin
               drem_ff <= drem_ff - dsor_ff[84:0];
            end
            q_ff    <= {q_ff[29:0], dge};
            dsor_ff <= {1'b0, dsor_ff[97:1]};
            iter_ff <= iter_ff + 7'd1;
         end
         ST_PICK: begin
            // strictly closer only: ties keep the earlier slot
            if (q_ff > tmin_ff && q_ff < best_ff) begin
               best_ff  <= q_ff;
               bslot_ff <= 4'(idx_ff);
               hit_ff   <= 1'b1;
            end
         end
         ST_NEXT: idx_ff <= idx_ff + 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= bslot_ff;
         rsp_dist_ff <= best_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {5'd0, rsp_dist_ff, rsp_slot_ff};

   // ---------------------------------------------------------------- checks
   a_best_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && $past(state_ff) != ST_IDLE) |-> best_ff <= $past(best_ff))
      else $error("closest distance grew during a search");

   a_table_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("table written while busy");

   a_sqrt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> iter_ff < 7'(SQRT_STEPS))
      else $error("square root ran past its last bit");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> rsp_slot_ff == 4'd0)
      else $error("miss reported with a nonzero slot");

endmodule
